@@ sv/cmva_pkg.sv @@
`default_nettype none

package cmva_pkg;

  localparam int DIM_W = 5;
  localparam int IDX_W = 4;
  localparam int VAL_W = 16;
  localparam int DEF_MAX_DIM = 16;
  localparam int DEF_FRAC_BITS = 14;

  localparam logic [DIM_W-1:0] DIM_RESET = 5'd2;
  localparam logic [DIM_W-1:0] CNT_MAX = 5'd31;

  localparam logic REQ_MATRIX = 1'b0;
  localparam logic REQ_VECTOR = 1'b1;

  typedef struct packed {
    logic             issue;
    logic             first;
    logic             last_col;
    logic             last_row;
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] col;
  } cmd_t;

  typedef struct packed {
    logic             launch;
    logic             run_done;
    logic [DIM_W-1:0] dim;
  } sts_t;

endpackage

`default_nettype wire

@@ sv/complex_matrix_vector_apply_top.sv @@
// Complex matrix times vector, signed Q2.14 (FRAC_BITS fraction bits). Each request
// writes one matrix coefficient or one vector amplitude, taken only while busy is low.
// The vector request marked last starts a run when the element count equals
// dim_in_use: busy then stays high until the last result leaves, while one complex
// MAC walks the matrix at one coefficient per cycle through a single read port of
// the matrix memory, and dim results leave, one per row, the last one marked. A
// count mismatch or an invalid dim_in_use gives one error result the cycle after
// the request, without raising busy. Results are valid for exactly one cycle on
// result_valid_o and cannot be held off. Write dim_in_use only while busy is low.
`default_nettype none

module complex_matrix_vector_apply_top #(
  parameter int MAX_DIM   = cmva_pkg::DEF_MAX_DIM,
  parameter int FRAC_BITS = cmva_pkg::DEF_FRAC_BITS
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               req_type_i,
  input  wire logic [cmva_pkg::IDX_W-1:0]         row_or_index_i,
  input  wire logic [cmva_pkg::IDX_W-1:0]         column_i,
  input  wire logic signed [cmva_pkg::VAL_W-1:0]  value_real_i,
  input  wire logic signed [cmva_pkg::VAL_W-1:0]  value_imag_i,
  input  wire logic                               vector_last_i,
  input  wire logic                               cfg_we_i,
  input  wire logic [cmva_pkg::DIM_W-1:0]         cfg_wdata_i,
  output logic                                    result_valid_o,
  output logic [cmva_pkg::IDX_W-1:0]              out_index_o,
  output logic signed [cmva_pkg::VAL_W-1:0]       out_real_o,
  output logic signed [cmva_pkg::VAL_W-1:0]       out_imag_o,
  output logic                                    out_last_o,
  output logic                                    size_error_o
);
  import cmva_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic accept;

  assign accept = start && !busy;

  cmva_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  cmva_dp #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .req_type_i     (req_type_i),
    .row_or_index_i (row_or_index_i),
    .column_i       (column_i),
    .value_real_i   (value_real_i),
    .value_imag_i   (value_imag_i),
    .vector_last_i  (vector_last_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .result_valid_o (result_valid_o),
    .out_index_o    (out_index_o),
    .out_real_o     (out_real_o),
    .out_imag_o     (out_imag_o),
    .out_last_o     (out_last_o),
    .size_error_o   (size_error_o)
  );

endmodule

`default_nettype wire

@@ sv/cmva_ctrl.sv @@
`default_nettype none

module cmva_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire cmva_pkg::sts_t sts_i,
  output cmva_pkg::cmd_t     cmd_o,
  output logic               busy_o
);
  import cmva_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MAC   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [DIM_W-1:0] row_q, row_d;
  logic [DIM_W-1:0] col_q, col_d;
  logic [DIM_W-1:0] dim_last;
  logic             col_end, row_end;

  assign dim_last = DIM_W'(sts_i.dim - 1'b1);
  assign col_end  = (col_q == dim_last);
  assign row_end  = (row_q == dim_last);

  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    col_d   = col_q;
    unique case (state_q)
      ST_IDLE: begin
        if (sts_i.launch) begin
          state_d = ST_MAC;
          row_d   = '0;
          col_d   = '0;
        end
      end
      ST_MAC: begin
        if (col_end) begin
          col_d = '0;
          if (row_end) begin
            state_d = ST_DRAIN;
          end else begin
            row_d = row_q + 1'b1;
          end
        end else begin
          col_d = col_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (sts_i.run_done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_q   <= '0;
      col_q   <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
    end
  end

  assign cmd_o.issue    = (state_q == ST_MAC);
  assign cmd_o.first    = (col_q == '0);
  assign cmd_o.last_col = col_end;
  assign cmd_o.last_row = row_end;
  assign cmd_o.row      = row_q;
  assign cmd_o.col      = col_q;
  assign busy_o         = (state_q != ST_IDLE);

  a_launch_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.launch |-> state_q == ST_IDLE)
    else $error("run launched while busy");

  a_launch_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.launch |=> state_q == ST_MAC && row_q == '0 && col_q == '0)
    else $error("run did not start at row 0 column 0");

  a_drain_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DRAIN && sts_i.run_done |=> state_q == ST_IDLE)
    else $error("run did not return to idle after the last row");

endmodule

`default_nettype wire

@@ sv/cmva_dp.sv @@
`default_nettype none

module cmva_dp #(
  parameter int MAX_DIM   = cmva_pkg::DEF_MAX_DIM,
  parameter int FRAC_BITS = cmva_pkg::DEF_FRAC_BITS
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               accept_i,
  input  wire logic                               req_type_i,
  input  wire logic [cmva_pkg::IDX_W-1:0]         row_or_index_i,
  input  wire logic [cmva_pkg::IDX_W-1:0]         column_i,
  input  wire logic signed [cmva_pkg::VAL_W-1:0]  value_real_i,
  input  wire logic signed [cmva_pkg::VAL_W-1:0]  value_imag_i,
  input  wire logic                               vector_last_i,
  input  wire logic                               cfg_we_i,
  input  wire logic [cmva_pkg::DIM_W-1:0]         cfg_wdata_i,
  input  wire cmva_pkg::cmd_t                     cmd_i,
  output cmva_pkg::sts_t                          sts_o,
  output logic                                    result_valid_o,
  output logic [cmva_pkg::IDX_W-1:0]              out_index_o,
  output logic signed [cmva_pkg::VAL_W-1:0]       out_real_o,
  output logic signed [cmva_pkg::VAL_W-1:0]       out_imag_o,
  output logic                                    out_last_o,
  output logic                                    size_error_o
);
  import cmva_pkg::*;

  localparam int VW     = $clog2(MAX_DIM);
  localparam int AW     = $clog2(MAX_DIM * MAX_DIM);
  localparam int WORD_W = 2 * VAL_W;
  localparam int PROD_W = 2 * VAL_W;
  localparam int TERM_W = PROD_W + 1;
  localparam int ACC_W  = TERM_W + 1 + $clog2(MAX_DIM);
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_LO   = -ACC_W'(32768);

  logic [WORD_W-1:0] mat_mem [MAX_DIM * MAX_DIM];
  logic [WORD_W-1:0] vec_mem [MAX_DIM];

  logic [DIM_W-1:0] dim_q;
  logic [DIM_W-1:0] vcnt_q, vcnt_d, vcnt_inc;
  logic             mat_we, vec_we, vec_end, size_ok;
  logic [AW-1:0]    mat_wa, mat_ra;
  logic [VW-1:0]    vec_wa, vec_ra;

  assign mat_we = accept_i && req_type_i == REQ_MATRIX
                  && 32'(row_or_index_i) < MAX_DIM && 32'(column_i) < MAX_DIM;
  assign vec_we = accept_i && req_type_i == REQ_VECTOR && 32'(row_or_index_i) < MAX_DIM;
  assign vec_end = accept_i && req_type_i == REQ_VECTOR && vector_last_i;
  assign mat_wa = AW'(32'(row_or_index_i) * MAX_DIM + 32'(column_i));
  assign vec_wa = VW'(row_or_index_i);
  assign mat_ra = AW'(32'(cmd_i.row) * MAX_DIM + 32'(cmd_i.col));
  assign vec_ra = VW'(cmd_i.col);

  assign vcnt_inc = (vcnt_q == CNT_MAX) ? vcnt_q : vcnt_q + 1'b1;
  assign size_ok  = dim_q != '0 && 32'(dim_q) <= MAX_DIM && vcnt_inc == dim_q;

  always_comb begin
    vcnt_d = vcnt_q;
    if (accept_i && req_type_i == REQ_VECTOR) begin
      vcnt_d = vector_last_i ? '0 : vcnt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q  <= DIM_RESET;
      vcnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        dim_q <= cfg_wdata_i;
      end
      vcnt_q <= vcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mat_we) begin
      mat_mem[mat_wa] <= {value_real_i, value_imag_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (vec_we) begin
      vec_mem[vec_wa] <= {value_real_i, value_imag_i};
    end
  end

  logic [WORD_W-1:0] mat_rd_q, vec_rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      mat_rd_q <= mat_mem[mat_ra];
      vec_rd_q <= vec_mem[vec_ra];
    end
  end

  logic             s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;
  logic [2:0]       s1_tag_q, s2_tag_q, s3_tag_q, s4_tag_q;
  logic [IDX_W-1:0] s1_row_q, s2_row_q, s3_row_q, s4_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= cmd_i.issue;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_tag_q <= {cmd_i.first, cmd_i.last_col, cmd_i.last_row};
    s1_row_q <= cmd_i.row[IDX_W-1:0];
    s2_tag_q <= s1_tag_q;
    s2_row_q <= s1_row_q;
    s3_tag_q <= s2_tag_q;
    s3_row_q <= s2_row_q;
    s4_tag_q <= s3_tag_q;
    s4_row_q <= s3_row_q;
  end

  logic signed [VAL_W-1:0]  m_re, m_im, v_re, v_im;
  logic signed [PROD_W-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [TERM_W-1:0] t_re_q, t_im_q;
  logic signed [ACC_W-1:0]  acc_re_q, acc_im_q, acc_re_d, acc_im_d;

  assign m_re = mat_rd_q[WORD_W-1:VAL_W];
  assign m_im = mat_rd_q[VAL_W-1:0];
  assign v_re = vec_rd_q[WORD_W-1:VAL_W];
  assign v_im = vec_rd_q[VAL_W-1:0];

  always_ff @(posedge clk_i) begin
    p_rr_q <= m_re * v_re;
    p_ii_q <= m_im * v_im;
    p_ri_q <= m_re * v_im;
    p_ir_q <= m_im * v_re;
    t_re_q <= TERM_W'(p_rr_q) - TERM_W'(p_ii_q);
    t_im_q <= TERM_W'(p_ri_q) + TERM_W'(p_ir_q);
  end

  always_comb begin
    if (s3_tag_q[2]) begin
      acc_re_d = ACC_W'(t_re_q);
      acc_im_d = ACC_W'(t_im_q);
    end else begin
      acc_re_d = acc_re_q + ACC_W'(t_re_q);
      acc_im_d = acc_im_q + ACC_W'(t_im_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_valid_q) begin
      acc_re_q <= acc_re_d;
      acc_im_q <= acc_im_d;
    end
  end

  function automatic logic signed [VAL_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] rnd;
    logic signed [ACC_W-1:0] q;
    rnd = acc + RND_HALF;
    q   = rnd >>> FRAC_BITS;
    if (q > SAT_HI) begin
      round_sat = VAL_W'(SAT_HI);
    end else if (q < SAT_LO) begin
      round_sat = VAL_W'(SAT_LO);
    end else begin
      round_sat = VAL_W'(q);
    end
  endfunction

  logic row_fire, err_fire;

  assign row_fire = s4_valid_q && s4_tag_q[1];
  assign err_fire = vec_end && !size_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= row_fire || err_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (err_fire) begin
      out_index_o  <= '0;
      out_real_o   <= '0;
      out_imag_o   <= '0;
      out_last_o   <= 1'b1;
      size_error_o <= 1'b1;
    end else if (row_fire) begin
      out_index_o  <= s4_row_q;
      out_real_o   <= round_sat(acc_re_q);
      out_imag_o   <= round_sat(acc_im_q);
      out_last_o   <= s4_tag_q[0];
      size_error_o <= 1'b0;
    end
  end

  assign sts_o.launch   = vec_end && size_ok;
  assign sts_o.run_done = row_fire && s4_tag_q[0];
  assign sts_o.dim      = dim_q;

  a_err_idle_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_fire |-> !s1_valid_q && !s2_valid_q && !s3_valid_q && !s4_valid_q)
    else $error("error result while a run is in flight");

  a_issue_reaches_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_valid_q |-> $past(cmd_i.issue, 4))
    else $error("accumulator stage valid without matching issue");

  a_err_marks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && size_error_o |-> out_last_o && out_index_o == '0)
    else $error("error result not marked last");

endmodule

`default_nettype wire
